// ===== hw/rtl/pibp_pkg.sv =====
// Package for the path interval bound propagator: widths, constants, types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pibp_pkg;
   localparam int MAX_NODES_DEF  = 32;
   localparam int VALUE_BITS_DEF = 32;
   localparam int FIELD_BITS     = 32;

   localparam logic ACT_SPAN = 1'b0;
   localparam logic ACT_NODE = 1'b1;

   typedef struct packed {
      logic                         action;
      logic signed [FIELD_BITS-1:0] lower_bound;
      logic signed [FIELD_BITS-1:0] upper_bound;
      logic signed [FIELD_BITS-1:0] transit_min;
      logic signed [FIELD_BITS-1:0] transit_max;
      logic                         final_node;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] cumul_min;
      logic signed [FIELD_BITS-1:0] cumul_max;
      logic signed [FIELD_BITS-1:0] span_min;
      logic signed [FIELD_BITS-1:0] span_max;
      logic                         feasible;
      logic                         last_result;
   } rsp_type;
endpackage
`default_nettype wire

// ===== hw/rtl/pibp_if.sv =====
// Valid/ready channel interface carrying a payload of a given type.
// Depends on pibp_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none
interface pibp_req_if;
   import pibp_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface pibp_rsp_if;
   import pibp_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pibp_front.sv =====
// Front end: accepts requests, clamps values and queues them as commands.
// Depends on pibp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pibp_front #(
   parameter int VALUE_BITS = pibp_pkg::VALUE_BITS_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   output logic                   in_ready,
   input  pibp_pkg::req_type      in_req,
   output logic                   cmd_valid,
   input  wire                    cmd_ready,
   output logic                   cmd_action,
   output logic                   cmd_final,
   output logic [4*VALUE_BITS-1:0] cmd_vals
);
   import pibp_pkg::*;
   localparam int QW = 2 + 4*VALUE_BITS;

   function automatic logic signed [VALUE_BITS-1:0] clampv(logic signed [FIELD_BITS-1:0] v);
      logic signed [63:0] w;
      logic signed [63:0] vmax;
      logic signed [63:0] vmin;
      w    = 64'(v);
      vmax = (64'sd1 <<< (VALUE_BITS-1)) - 64'sd1;
      vmin = -vmax - 64'sd1;
      if (w > vmax) w = vmax;
      if (w < vmin) w = vmin;
      return w[VALUE_BITS-1:0];
   endfunction

   // Two-entry queue.
   logic [QW-1:0] q_ff [2];
   logic [QW-1:0] q_in [2];
   logic [1:0]    cnt_ff, cnt_in;
   logic [QW-1:0] word;
   logic          push, pop;

   assign word = {in_req.action, in_req.final_node,
                  clampv(in_req.lower_bound), clampv(in_req.upper_bound),
                  clampv(in_req.transit_min), clampv(in_req.transit_max)};
   assign in_ready  = (cnt_ff != 2'd2);
   assign push      = in_valid && in_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd_action = q_ff[0][QW-1];
   assign cmd_final  = q_ff[0][QW-2];
   assign cmd_vals   = q_ff[0][4*VALUE_BITS-1:0];

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      cnt_in  = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         cnt_in  = cnt_in - 2'd1;
      end
      if (push) begin
         if (cnt_in == 2'd0) q_in[0] = word;
         else q_in[1] = word;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
   end
endmodule
`default_nettype wire

// ===== hw/rtl/pibp_back.sv =====
// Back end: node memories, propagation sequencer and result output register.
// Depends on pibp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pibp_back #(
   parameter int MAX_NODES  = pibp_pkg::MAX_NODES_DEF,
   parameter int VALUE_BITS = pibp_pkg::VALUE_BITS_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     cmd_valid,
   output logic                    cmd_ready,
   input  wire                     cmd_action,
   input  wire                     cmd_final,
   input  wire [4*VALUE_BITS-1:0]  cmd_vals,
   output logic                    out_valid,
   input  wire                     out_ready,
   output pibp_pkg::rsp_type       out_rsp
);
   import pibp_pkg::*;
   localparam int VB = VALUE_BITS;
   localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CW = $clog2(MAX_NODES + 1);
   typedef logic signed [VB-1:0] val_type;
   localparam logic signed [VB:0] VMAX = {2'b00, {(VB-1){1'b1}}};
   localparam logic signed [VB:0] VMIN = {2'b11, {(VB-1){1'b0}}};

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_A1   = 4'd1;  // write front node, start forward pass
   localparam logic [3:0] ST_A2   = 4'd2;  // meet back with front+span, front with back-span
   localparam logic [3:0] ST_FWD  = 4'd3;
   localparam logic [3:0] ST_SF   = 4'd4;
   localparam logic [3:0] ST_BWD  = 4'd5;
   localparam logic [3:0] ST_SB   = 4'd6;
   localparam logic [3:0] ST_SPAN = 4'd7;
   localparam logic [3:0] ST_OUT  = 4'd8;
   localparam logic [3:0] ST_FAIL = 4'd9;
   localparam logic [3:0] ST_RD   = 4'd10;  // wait for read data
   localparam logic [3:0] ST_LD   = 4'd11;  // front read after the last node write

   function automatic val_type sat(logic signed [VB:0] w);
      if (w > VMAX) return VMAX[VB-1:0];
      if (w < VMIN) return VMIN[VB-1:0];
      return w[VB-1:0];
   endfunction
   function automatic val_type sadd(val_type a, val_type b);
      return sat((VB+1)'(a) + (VB+1)'(b));
   endfunction
   function automatic val_type ssub(val_type a, val_type b);
      return sat((VB+1)'(a) - (VB+1)'(b));
   endfunction

   // Memories (cumul: lo,hi ; transit: lo,hi).
   logic [2*VB-1:0] cmem [MAX_NODES];
   logic [2*VB-1:0] tmem [MAX_NODES];
   logic [2*VB-1:0] c_rd_ff, t_rd_ff;
   logic [AW-1:0]   c_ra, t_ra, wa;
   logic [2*VB-1:0] wd;
   logic            we;

   logic [3:0]     st_ff, st_in, ret_ff, ret_in;
   logic [CW-1:0]  cnt_ff, cnt_in, n_ff, n_in;
   logic [AW-1:0]  idx_ff, idx_in;
   val_type        sp_lo_ff, sp_lo_in, sp_hi_ff, sp_hi_in;
   val_type        cur_lo_ff, cur_lo_in, cur_hi_ff, cur_hi_in;
   val_type        f_lo_ff, f_lo_in, f_hi_ff, f_hi_in;  // front node copy
   logic           ov_ff, ov_in;
   rsp_type        o_ff, o_in;
   logic [AW-1:0]  last_idx;
   val_type        m_lo, m_hi, rc_lo, rc_hi, rt_lo, rt_hi, ns_lo, ns_hi;

   always_ff @(posedge clock) begin
      if (we) cmem[wa] <= wd;
      c_rd_ff <= cmem[c_ra];
      t_rd_ff <= tmem[t_ra];
      if (cmd_valid && cmd_ready && cmd_action == ACT_NODE && cnt_ff != CW'(MAX_NODES))
         tmem[cnt_ff[AW-1:0]] <= cmd_vals[2*VB-1:0];
   end

   assign last_idx = AW'(n_ff - CW'(1));
   assign rc_lo = c_rd_ff[2*VB-1:VB];
   assign rc_hi = c_rd_ff[VB-1:0];
   assign rt_lo = t_rd_ff[2*VB-1:VB];
   assign rt_hi = t_rd_ff[VB-1:0];
   // meet of cur with read cumul
   assign m_lo = (rc_lo > cur_lo_ff) ? rc_lo : cur_lo_ff;
   assign m_hi = (rc_hi < cur_hi_ff) ? rc_hi : cur_hi_ff;

   assign cmd_ready = (st_ff == ST_IDLE);
   assign out_valid = ov_ff;
   assign out_rsp   = o_ff;

   always_comb begin
      st_in = st_ff; ret_in = ret_ff; cnt_in = cnt_ff; n_in = n_ff; idx_in = idx_ff;
      sp_lo_in = sp_lo_ff; sp_hi_in = sp_hi_ff;
      cur_lo_in = cur_lo_ff; cur_hi_in = cur_hi_ff;
      f_lo_in = f_lo_ff; f_hi_in = f_hi_ff;
      ov_in = ov_ff; o_in = o_ff;
      we = 1'b0; wa = idx_ff; wd = {m_lo, m_hi};
      c_ra = idx_ff; t_ra = idx_ff;
      ns_lo = '0; ns_hi = '0;
      if (ov_ff && out_ready) ov_in = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd_action == ACT_SPAN) begin
                  sp_lo_in = cmd_vals[4*VB-1:3*VB];
                  sp_hi_in = cmd_vals[3*VB-1:2*VB];
               end else begin
                  if (cnt_ff != CW'(MAX_NODES)) begin
                     we = 1'b1; wa = cnt_ff[AW-1:0];
                     wd = cmd_vals[4*VB-1:2*VB];
                     cnt_in = cnt_ff + CW'(1);
                  end
                  if (cmd_final) begin
                     n_in = cnt_in; cnt_in = '0;
                     idx_in = '0; st_in = ST_LD;
                  end
               end
            end
         end
         ST_LD: begin
            // the node written last cycle is visible now; read the front node
            st_in = ST_RD; ret_in = ST_A1;
         end
         ST_RD: begin
            // memory read of idx issued last cycle
            st_in = ret_ff;
            if (ret_ff == ST_FWD || ret_ff == ST_SB) t_ra = idx_ff - AW'(1);
            if (ret_ff == ST_A1) begin
               // front node now in c_rd; latch it, read back node
               idx_in = last_idx; st_in = ST_RD; ret_in = ST_A2;
               c_ra = last_idx;
               f_lo_in = rc_lo; f_hi_in = rc_hi;
               cur_lo_in = sadd(rc_lo, sp_lo_ff);
               cur_hi_in = sadd(rc_hi, sp_hi_ff);
            end
         end
         ST_A2: begin
            // c_rd = back node; cur = front+span; meet and write back
            if (m_lo > m_hi) st_in = ST_FAIL;
            else begin
               we = 1'b1; wa = last_idx;
               ns_lo = ssub(m_lo, sp_hi_ff); ns_hi = ssub(m_hi, sp_lo_ff);
               // With one node the front is the back entry just refined.
               if (n_ff == CW'(1)) begin
                  f_lo_in = m_lo; f_hi_in = m_hi;
               end
               // meet front with back-span
               f_lo_in = (ns_lo > f_lo_in) ? ns_lo : f_lo_in;
               f_hi_in = (ns_hi < f_hi_in) ? ns_hi : f_hi_in;
               if (f_lo_in > f_hi_in) st_in = ST_FAIL;
               else begin
                  st_in = ST_A1;
               end
            end
         end
         ST_A1: begin
            // write front node, start forward pass
            we = 1'b1; wa = '0; wd = {f_lo_ff, f_hi_ff};
            cur_lo_in = f_lo_ff; cur_hi_in = f_hi_ff;
            idx_in = '0;
            if (n_ff == CW'(1)) begin
               // forward pass empty; span to front from back (= front)
               cur_lo_in = ssub(f_lo_ff, sp_hi_ff); cur_hi_in = ssub(f_hi_ff, sp_lo_ff);
               c_ra = '0; st_in = ST_RD; ret_in = ST_SF;
            end else begin
               t_ra = '0; c_ra = AW'(1); idx_in = AW'(1); st_in = ST_RD; ret_in = ST_FWD;
            end
         end
         ST_FWD: begin
            // cur += transit[idx-1] then meet c[idx]
            cur_lo_in = sadd(cur_lo_ff, rt_lo); cur_hi_in = sadd(cur_hi_ff, rt_hi);
            ns_lo = (rc_lo > cur_lo_in) ? rc_lo : cur_lo_in;
            ns_hi = (rc_hi < cur_hi_in) ? rc_hi : cur_hi_in;
            cur_lo_in = ns_lo; cur_hi_in = ns_hi;
            if (ns_lo > ns_hi) st_in = ST_FAIL;
            else begin
               we = 1'b1; wd = {ns_lo, ns_hi};
               if (idx_ff == last_idx) begin
                  cur_lo_in = ssub(ns_lo, sp_hi_ff); cur_hi_in = ssub(ns_hi, sp_lo_ff);
                  idx_in = '0; c_ra = '0; st_in = ST_RD; ret_in = ST_SF;
               end else begin
                  t_ra = idx_ff; c_ra = idx_ff + AW'(1);
                  idx_in = idx_ff + AW'(1); st_in = ST_RD; ret_in = ST_FWD;
               end
            end
         end
         ST_SF: begin
            if (m_lo > m_hi) st_in = ST_FAIL;
            else if (m_lo == rc_lo && m_hi == rc_hi || idx_ff == last_idx) begin
               if (!(m_lo == rc_lo && m_hi == rc_hi)) we = 1'b1;
               // start backward pass from back node
               c_ra = last_idx; idx_in = last_idx; st_in = ST_RD; ret_in = ST_BWD;
               cur_lo_in = '0; cur_hi_in = '0;
               ret_in = ST_BWD;
            end else begin
               we = 1'b1;
               cur_lo_in = sadd(m_lo, rt_lo); cur_hi_in = sadd(m_hi, rt_hi);
               c_ra = idx_ff + AW'(1); t_ra = idx_ff + AW'(1);
               idx_in = idx_ff + AW'(1); st_in = ST_RD;
            end
         end
         ST_BWD: begin
            // first visit (idx = last): load cur from back node
            if (idx_ff == last_idx) begin
               cur_lo_in = rc_lo; cur_hi_in = rc_hi;
               if (n_ff == CW'(1)) begin
                  // the single node is also the front; keep its latest value
                  f_lo_in = rc_lo; f_hi_in = rc_hi;
                  c_ra = '0; idx_in = '0; st_in = ST_RD; ret_in = ST_SB;
                  cur_lo_in = sadd(rc_lo, sp_lo_ff); cur_hi_in = sadd(rc_hi, sp_hi_ff);
                  idx_in = last_idx; c_ra = last_idx;
               end else begin
                  t_ra = idx_ff - AW'(1); c_ra = idx_ff - AW'(1);
                  idx_in = idx_ff - AW'(1); st_in = ST_RD; ret_in = ST_BWD;
               end
            end else begin
               ns_lo = ssub(cur_lo_ff, rt_hi); ns_hi = ssub(cur_hi_ff, rt_lo);
               ns_lo = (rc_lo > ns_lo) ? rc_lo : ns_lo;
               ns_hi = (rc_hi < ns_hi) ? rc_hi : ns_hi;
               cur_lo_in = ns_lo; cur_hi_in = ns_hi;
               if (ns_lo > ns_hi) st_in = ST_FAIL;
               else begin
                  we = 1'b1; wd = {ns_lo, ns_hi};
                  if (idx_ff == '0) begin
                     f_lo_in = ns_lo; f_hi_in = ns_hi;
                     cur_lo_in = sadd(ns_lo, sp_lo_ff); cur_hi_in = sadd(ns_hi, sp_hi_ff);
                     c_ra = last_idx; t_ra = last_idx - AW'(1);
                     idx_in = last_idx; st_in = ST_RD; ret_in = ST_SB;
                  end else begin
                     t_ra = idx_ff - AW'(1); c_ra = idx_ff - AW'(1);
                     idx_in = idx_ff - AW'(1); st_in = ST_RD; ret_in = ST_BWD;
                  end
               end
            end
         end
         ST_SB: begin
            if (m_lo > m_hi) st_in = ST_FAIL;
            else if (m_lo == rc_lo && m_hi == rc_hi || idx_ff == '0) begin
               if (!(m_lo == rc_lo && m_hi == rc_hi)) we = 1'b1;
               // read back and front for span refinement
               c_ra = last_idx; st_in = ST_RD; ret_in = ST_SPAN; idx_in = last_idx;
               if (idx_ff == '0 && !(m_lo == rc_lo && m_hi == rc_hi)) begin
                  f_lo_in = m_lo; f_hi_in = m_hi;
               end
            end else begin
               we = 1'b1;
               cur_lo_in = ssub(m_lo, rt_hi); cur_hi_in = ssub(m_hi, rt_lo);
               c_ra = idx_ff - AW'(1); t_ra = idx_ff - AW'(2);
               idx_in = idx_ff - AW'(1); st_in = ST_RD;
            end
         end
         ST_SPAN: begin
            // c_rd = back node (bypass-safe: the ST_RD re-read follows any ST_SB write)
            ns_lo = ssub(rc_lo, f_hi_ff); ns_hi = ssub(rc_hi, f_lo_ff);
            ns_lo = (ns_lo > sp_lo_ff) ? ns_lo : sp_lo_ff;
            ns_hi = (ns_hi < sp_hi_ff) ? ns_hi : sp_hi_ff;
            if (ns_lo > ns_hi) st_in = ST_FAIL;
            else begin
               sp_lo_in = ns_lo; sp_hi_in = ns_hi;
               idx_in = '0; c_ra = '0; st_in = ST_RD; ret_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!ov_ff || out_ready) begin
               ov_in = 1'b1;
               o_in = '0;
               o_in.cumul_min = FIELD_BITS'(rc_lo);
               o_in.cumul_max = FIELD_BITS'(rc_hi);
               o_in.feasible  = 1'b1;
               if (idx_ff == last_idx) begin
                  o_in.span_min = FIELD_BITS'(sp_lo_ff);
                  o_in.span_max = FIELD_BITS'(sp_hi_ff);
                  o_in.last_result = 1'b1;
                  st_in = ST_IDLE;
               end else begin
                  c_ra = idx_ff + AW'(1); idx_in = idx_ff + AW'(1);
                  st_in = ST_RD; ret_in = ST_OUT;
               end
            end else begin
               c_ra = idx_ff; st_in = ST_RD; ret_in = ST_OUT;
            end
         end
         ST_FAIL: begin
            if (!ov_ff || out_ready) begin
               ov_in = 1'b1; o_in = '0; o_in.last_result = 1'b1;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; ret_ff <= ST_IDLE; cnt_ff <= '0; ov_ff <= 1'b0;
         sp_lo_ff <= '0; sp_hi_ff <= '0;
      end else begin
         st_ff <= st_in; ret_ff <= ret_in; cnt_ff <= cnt_in; ov_ff <= ov_in;
         sp_lo_ff <= sp_lo_in; sp_hi_ff <= sp_hi_in;
      end
      n_ff <= n_in; idx_ff <= idx_in;
      cur_lo_ff <= cur_lo_in; cur_hi_ff <= cur_hi_in;
      f_lo_ff <= f_lo_in; f_hi_ff <= f_hi_in;
      o_ff <= o_in;
   end
endmodule
`default_nettype wire

// ===== hw/rtl/path_interval_bound_propagator_core.sv =====
// Top level of the path interval bound propagator.
// Depends on pibp_pkg, pibp_if, pibp_front and pibp_back.
//
// Usage: a request with action 0 loads the span interval; a request with
// action 1 loads one node. A node request with final_node set starts the
// tightening passes over the stored path. The block then returns one
// response per node, the last one carrying the refined span, or a single
// response with feasible low when any intersection is empty.
// The back end takes node loads while it is idle. Every node visit in a
// pass includes a wait state for the single read port of the node
// memory, and each response is read from that memory through the same
// wait state. How long a run lasts depends on how early the span
// re-propagation passes settle. A two-entry request queue lets the
// requester keep loading while the back end is busy. Reset clears the node
// count, the span and all handshake state; memory contents are not cleared.
// When the receiver stalls, the response register holds and the sequencer
// waits.
`timescale 1ns / 1ps
`default_nettype none
module path_interval_bound_propagator_core #(
   parameter int MAX_NODES  = pibp_pkg::MAX_NODES_DEF,
   parameter int VALUE_BITS = pibp_pkg::VALUE_BITS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   pibp_req_if.sink    req,
   pibp_rsp_if.source  rsp
);
   import pibp_pkg::*;
   logic                    cmd_valid, cmd_ready, cmd_action, cmd_final;
   logic [4*VALUE_BITS-1:0] cmd_vals;

   // Front end queues and clamps incoming requests.
   pibp_front #(.VALUE_BITS(VALUE_BITS)) u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_req(req.payload),
      .cmd_valid, .cmd_ready, .cmd_action, .cmd_final, .cmd_vals
   );

   // Back end stores the path and runs the passes.
   pibp_back #(.MAX_NODES(MAX_NODES), .VALUE_BITS(VALUE_BITS)) u_back (
      .clock, .reset,
      .cmd_valid, .cmd_ready, .cmd_action, .cmd_final, .cmd_vals,
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_rsp(rsp.payload)
   );
endmodule
`default_nettype wire

// ===== hw/rtl/pibp_checker.sv =====
// Port-level checker for the propagator core, bound to the top level.
// Depends on pibp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pibp_checker (
   input wire               clock,
   input wire               reset,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input pibp_pkg::rsp_type rsp_payload
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response dropped under stall");
   a_fail_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.feasible |-> rsp_payload.last_result)
      else $error("infeasible response not last");
   a_span_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last_result |-> rsp_payload.span_min == '0
      && rsp_payload.span_max == '0)
      else $error("span on non-last response");
endmodule

bind path_interval_bound_propagator_core pibp_checker u_chk (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_payload(rsp.payload)
);
`default_nettype wire

// ===== dv/tb_path_interval_bound_propagator_core.sv =====
// Testbench for path_interval_bound_propagator_core: directed and random paths checked
// against a built-in interval propagation predictor. Depends on pibp_pkg and pibp_if.
`timescale 1ns / 1ps
module tb_path_interval_bound_propagator_core;
   import pibp_pkg::*;

   localparam int     NODE_CAP   = MAX_NODES_DEF;
   localparam longint VAL_MAX    = 64'sd2147483647;
   localparam longint VAL_MIN    = -64'sd2147483648;
   localparam int     IDLE_LIMIT = 20000;
   localparam int     DRAIN_WAIT = 12 * NODE_CAP + 100;

   typedef struct {
      longint lo;
      longint hi;
   } span_t;

   logic clock;
   logic reset;
   pibp_req_if req_ch ();
   pibp_rsp_if rsp_ch ();

   path_interval_bound_propagator_core u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Predictor state: a copy of the node store, the span and the node count.
   span_t   cumul_mem [NODE_CAP];
   span_t   transit_mem [NODE_CAP];
   span_t   path_span;
   int      nodes_held;
   rsp_type bounds_due[$];

   int      error_count;
   int      idle_cycles;
   bit      gaps_on;

   always #5 clock = ~clock;

   function automatic longint clamp_val(longint v);
      if (v > VAL_MAX) return VAL_MAX;
      if (v < VAL_MIN) return VAL_MIN;
      return v;
   endfunction

   function automatic span_t span_add(span_t a, span_t b);
      span_t r;
      r.lo = clamp_val(a.lo + b.lo);
      r.hi = clamp_val(a.hi + b.hi);
      return r;
   endfunction

   function automatic span_t span_sub(span_t a, span_t b);
      span_t r;
      r.lo = clamp_val(a.lo - b.hi);
      r.hi = clamp_val(a.hi - b.lo);
      return r;
   endfunction

   // Intersect a with b in place; returns 0 when the result is empty.
   function automatic bit span_meet(inout span_t a, input span_t b);
      if (b.lo > a.lo) a.lo = b.lo;
      if (b.hi < a.hi) a.hi = b.hi;
      return a.lo <= a.hi;
   endfunction

   // All tightening passes over the first n stored nodes.
   function automatic bit tighten_path(input int n, output span_t sp_out);
      span_t sp;
      span_t cur;
      int    t;
      sp = path_span;
      sp_out = sp;
      if (!span_meet(cumul_mem[n-1], span_add(cumul_mem[0], sp))) return 0;
      if (!span_meet(cumul_mem[0], span_sub(cumul_mem[n-1], sp))) return 0;
      cur = cumul_mem[0];
      for (t = 0; t < n - 1; t++) begin
         cur = span_add(cur, transit_mem[t]);
         if (!span_meet(cur, cumul_mem[t+1])) return 0;
         cumul_mem[t+1] = cur;
      end
      cur = span_sub(cumul_mem[n-1], sp);
      for (t = 0; t < n; t++) begin
         if (!span_meet(cur, cumul_mem[t])) return 0;
         if (cur.lo == cumul_mem[t].lo && cur.hi == cumul_mem[t].hi) break;
         cumul_mem[t] = cur;
         if (t == n - 1) break;
         cur = span_add(cur, transit_mem[t]);
      end
      cur = cumul_mem[n-1];
      for (t = n - 2; t >= 0; t--) begin
         cur = span_sub(cur, transit_mem[t]);
         if (!span_meet(cur, cumul_mem[t])) return 0;
         cumul_mem[t] = cur;
      end
      cur = span_add(cumul_mem[0], sp);
      for (t = n - 1; t >= 0; t--) begin
         if (!span_meet(cur, cumul_mem[t])) return 0;
         if (cur.lo == cumul_mem[t].lo && cur.hi == cumul_mem[t].hi) break;
         cumul_mem[t] = cur;
         if (t == 0) break;
         cur = span_sub(cur, transit_mem[t-1]);
      end
      if (!span_meet(sp, span_sub(cumul_mem[n-1], cumul_mem[0]))) return 0;
      sp_out = sp;
      return 1;
   endfunction

   // Update the predictor for one accepted request and queue the bounds it causes.
   function automatic void predict_request(req_type r);
      span_t   sp;
      rsp_type o;
      int      n;
      if (r.action == ACT_SPAN) begin
         path_span.lo = longint'(r.lower_bound);
         path_span.hi = longint'(r.upper_bound);
         return;
      end
      if (nodes_held < NODE_CAP) begin
         cumul_mem[nodes_held].lo   = longint'(r.lower_bound);
         cumul_mem[nodes_held].hi   = longint'(r.upper_bound);
         transit_mem[nodes_held].lo = longint'(r.transit_min);
         transit_mem[nodes_held].hi = longint'(r.transit_max);
         nodes_held++;
      end
      if (!r.final_node) return;
      n = nodes_held;
      nodes_held = 0;
      if (!tighten_path(n, sp)) begin
         o = '0;
         o.last_result = 1'b1;
         bounds_due.push_back(o);
         return;
      end
      path_span = sp;
      for (int k = 0; k < n; k++) begin
         o = '0;
         o.cumul_min = cumul_mem[k].lo[31:0];
         o.cumul_max = cumul_mem[k].hi[31:0];
         if (k == n - 1) begin
            o.span_min    = sp.lo[31:0];
            o.span_max    = sp.hi[31:0];
            o.last_result = 1'b1;
         end
         o.feasible = 1'b1;
         bounds_due.push_back(o);
      end
   endfunction

   // Send one request, wait for its acceptance, then maybe leave a gap.
   task automatic send_request(input logic act, input int lo, input int hi,
                               input int tmin, input int tmax, input logic fin);
      req_type r;
      r.action      = act;
      r.lower_bound = lo;
      r.upper_bound = hi;
      r.transit_min = tmin;
      r.transit_max = tmax;
      r.final_node  = fin;
      req_ch.valid   <= 1'b1;
      req_ch.payload <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_request(r);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic send_node(input int lo, input int hi, input int tmin, input int tmax,
                            input logic fin);
      send_request(ACT_NODE, lo, hi, tmin, tmax, fin);
   endtask

   task automatic send_span(input int lo, input int hi);
      send_request(ACT_SPAN, lo, hi, $urandom, $urandom, 1'($urandom_range(0, 1)));
   endtask

   // A path that is likely to stay feasible: cumul windows around a rising value.
   task automatic send_plausible_path(input int n);
      int base;
      int step;
      base = $urandom_range(0, 2000) - 1000;
      send_span(n * 5, n * 60);
      for (int k = 0; k < n; k++) begin
         step = $urandom_range(1, 40);
         send_node(base - $urandom_range(0, 50), base + $urandom_range(0, 400),
                   step, step + $urandom_range(0, 30), k == n - 1);
         base = base + step;
      end
   endtask

   task automatic test_single_node();
      send_span(0, 100);
      send_node(5, 10, 3, 4, 1'b1);
      send_span(-10, 10);
      send_node(-20, 20, 0, 0, 1'b1);
   endtask

   task automatic test_extremes();
      send_span(int'(VAL_MIN), int'(VAL_MAX));
      send_node(int'(VAL_MIN), int'(VAL_MAX), int'(VAL_MAX), int'(VAL_MAX), 1'b0);
      send_node(int'(VAL_MIN), int'(VAL_MAX), int'(VAL_MIN), int'(VAL_MIN), 1'b0);
      send_node(int'(VAL_MIN), int'(VAL_MAX), int'(VAL_MIN), int'(VAL_MAX), 1'b1);
      send_span(int'(VAL_MAX), int'(VAL_MAX));
      send_node(int'(VAL_MIN), int'(VAL_MIN), 0, 0, 1'b0);
      send_node(int'(VAL_MAX), int'(VAL_MAX), -1, -1, 1'b1);
   endtask

   task automatic test_infeasible();
      // A reversed interval is loaded as it is and normally empties an intersection.
      send_span(0, 50);
      send_node(30, 10, 1, 2, 1'b0);
      send_node(0, 100, 1, 2, 1'b1);
      // Span too short for the transits.
      send_span(0, 1);
      send_node(0, 0, 10, 10, 1'b0);
      send_node(0, 100, 0, 0, 1'b1);
   endtask

   task automatic test_store_full();
      // Nodes beyond the store capacity are dropped; the last one still starts the run.
      send_span(0, 1000000);
      for (int k = 0; k < NODE_CAP + 2; k++)
         send_node(k * 10 - 5, k * 10 + 50, 8, 12, k == NODE_CAP + 1);
   endtask

   task automatic test_random_paths(input int items);
      int sent;
      int n;
      sent = 0;
      while (sent < items) begin
         if (sent > items * 3 / 4) gaps_on = 0;
         case ($urandom_range(0, 9))
            0: begin
               // Raw noise: every bound and transit field random.
               n = $urandom_range(1, 4);
               if ($urandom_range(0, 1)) send_span($urandom, $urandom);
               for (int k = 0; k < n; k++)
                  send_node($urandom, $urandom, $urandom, $urandom, k == n - 1);
               sent += n + 1;
            end
            1: begin
               n = ($urandom_range(0, 5) == 0) ? NODE_CAP : $urandom_range(2, 12);
               send_plausible_path(n);
               sent += n + 1;
            end
            default: begin
               n = $urandom_range(1, 8);
               send_plausible_path(n);
               sent += n + 1;
            end
         endcase
      end
   endtask

   task automatic report_field(input string name, input longint want, input longint got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
   endtask

   // Response checker.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         if (bounds_due.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            error_count++;
         end else begin
            want = bounds_due.pop_front();
            if (got.cumul_min !== want.cumul_min)
               report_field("cumul_min", want.cumul_min, got.cumul_min);
            if (got.cumul_max !== want.cumul_max)
               report_field("cumul_max", want.cumul_max, got.cumul_max);
            if (got.span_min !== want.span_min)
               report_field("span_min", want.span_min, got.span_min);
            if (got.span_max !== want.span_max)
               report_field("span_max", want.span_max, got.span_max);
            if (got.feasible !== want.feasible)
               report_field("feasible", want.feasible, got.feasible);
            if (got.last_result !== want.last_result)
               report_field("last_result", want.last_result, got.last_result);
         end
      end
   end

   // Receiver stalls in random bursts while gaps are enabled.
   always @(posedge clock) begin
      int stall_left;
      if (reset) begin
         stall_left = 0;
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 13);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Watchdog on cycles with no handshake on either channel.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("path_interval_bound_propagator_core verification failed");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      error_count = 0;
      gaps_on     = 1;
      nodes_held  = 0;
      path_span.lo = 0;
      path_span.hi = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_node();
      test_extremes();
      test_infeasible();
      test_store_full();
      test_random_paths(250);

      req_ch.valid <= 1'b0;
      while (bounds_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0 && bounds_due.size() == 0) begin
         $display("path_interval_bound_propagator_core verification clean");
      end else begin
         $display("path_interval_bound_propagator_core verification failed");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
hw/rtl/pibp_pkg.sv
hw/rtl/pibp_if.sv
hw/rtl/pibp_front.sv
hw/rtl/pibp_back.sv
hw/rtl/path_interval_bound_propagator_core.sv
hw/rtl/pibp_checker.sv
dv/tb_path_interval_bound_propagator_core.sv
